[rtl/core/fcca_pkg.sv]
// Shared types and constants for the FAT12 cluster chain allocator.
// No dependencies; every other file in rtl/core uses it through scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fcca_pkg;

	// Widest table address the ports can name (8192 bytes).
	localparam int unsigned ADDR_W = 13;

	localparam logic [11:0] END_MARK   = 12'hFFF;
	localparam logic [11:0] FREE_ENTRY = 12'h000;
	localparam logic [12:0] SCAN_START = 13'd2;

	typedef enum logic [1:0] {
		MODE_WR_BYTE  = 2'd0,
		MODE_RD_BYTE  = 2'd1,
		MODE_FILE_BLK = 2'd2,
		MODE_NONE     = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_SCAN_C,
		ST_WR_LO,
		ST_WR_HI,
		ST_DONE
	} state_t;

	// What the current entry pass is doing.
	typedef enum logic [1:0] {
		PH_FIRST,
		PH_LINK,
		PH_FETCH
	} phase_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [12:0] byte_index;
		logic [7:0]  byte_value;
		logic        last_block;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [11:0] cluster;
		logic [12:0] sector;
		logic        status;
	} out_word_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

	// Decoded view of one packed 12-bit entry.
	typedef struct packed {
		logic [ADDR_W-1:0] off_lo;
		logic [ADDR_W-1:0] off_hi;
		logic              fits;
		logic [11:0]       value;
		logic [7:0]        wr_lo;
		logic [7:0]        wr_hi;
	} entry_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} result_t;

endpackage

`default_nettype wire

[rtl/core/fcca_table_ram.sv]
// Byte-wide FAT table storage: one port, registered read data.
// Depends on fcca_pkg for the request struct.
`timescale 1ns / 1ps
`default_nettype none

module fcca_table_ram #(
	parameter int unsigned DEPTH = 8192
) (
	input  wire logic              clk,
	input  wire fcca_pkg::ram_req_t req,
	output logic [7:0]             rdata
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		rdata <= mem[req.addr[AW-1:0]];
	end

endmodule

`default_nettype wire

[rtl/core/fcca_entry_unit.sv]
// Shared entry unit: byte offsets of a 12-bit entry, table bounds check,
// nibble-split decode and read-modify-write merge. Depends on fcca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcca_entry_unit #(
	parameter int unsigned TABLE_BYTES = 8192
) (
	input  wire logic [12:0]    idx,
	input  wire logic [7:0]     b0,
	input  wire logic [7:0]     b1,
	input  wire logic [11:0]    val,
	output fcca_pkg::entry_t    ent
);

	localparam logic [13:0] LAST_OFF = 14'(TABLE_BYTES - 1);

	logic [13:0] off;
	logic [13:0] off_nxt;
	logic        odd;

	// offset = floor(3i/2) = i + i/2
	assign off     = {1'b0, idx} + {2'b00, idx[12:1]};
	assign off_nxt = off + 14'd1;
	assign odd     = idx[0];

	always_comb begin
		ent.off_lo = off[fcca_pkg::ADDR_W-1:0];
		ent.off_hi = off_nxt[fcca_pkg::ADDR_W-1:0];
		ent.fits   = (off < LAST_OFF);
		if (odd) begin
			ent.value = {b1, b0[7:4]};
			ent.wr_lo = {val[3:0], b0[3:0]};
			ent.wr_hi = val[11:4];
		end else begin
			ent.value = {b1[3:0], b0};
			ent.wr_lo = val[7:0];
			ent.wr_hi = {b1[7:4], val[11:8]};
		end
	end

endmodule

`default_nettype wire

[rtl/core/fcca_ctrl.sv]
// Sequencer: byte access, free-entry scans and entry updates, one table byte
// at a time through the entry unit. Depends on fcca_pkg, fcca_entry_unit.
`timescale 1ns / 1ps
`default_nettype none

module fcca_ctrl #(
	parameter int unsigned TABLE_BYTES   = 8192,
	parameter int unsigned SECTOR_OFFSET = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire fcca_pkg::in_word_t  in_data,
	output logic                     in_stall,
	input  wire logic [11:0]         highest,
	input  wire logic [7:0]          rdata,
	output fcca_pkg::ram_req_t       ram_req,
	output fcca_pkg::result_t        res,
	input  wire logic                res_take
);

	localparam logic [13:0] TBL_LIM = 14'(TABLE_BYTES);
	localparam logic [12:0] SEC_OFS = 13'(SECTOR_OFFSET);

	fcca_pkg::state_t state_q, state_d;
	fcca_pkg::phase_t phase_q, phase_d;
	logic             open_q, open_d;
	logic [11:0]      cur_q, cur_d;

	logic [12:0] idx_q, idx_d;
	logic [11:0] c_q, c_d;
	logic [11:0] val_q, val_d;
	logic [7:0]  b0_q, b0_d;
	logic [7:0]  b1_q, b1_d;
	logic        last_q, last_d;
	logic        st_q, st_d;
	logic        clv_q, clv_d;
	logic [7:0]  rdb_q, rdb_d;
	logic        rng_q, rng_d;

	logic              in_rng;
	logic              over_lim;
	logic [7:0]        eu_b1;
	fcca_pkg::entry_t  ent;

	assign eu_b1 = (state_q == fcca_pkg::ST_SCAN_C) ? rdata : b1_q;

	fcca_entry_unit #(
		.TABLE_BYTES (TABLE_BYTES)
	) u_entry (
		.idx (idx_q),
		.b0  (b0_q),
		.b1  (eu_b1),
		.val (val_q),
		.ent (ent)
	);

	assign in_rng   = ({1'b0, in_data.byte_index} < TBL_LIM);
	assign over_lim = (idx_q > {1'b0, highest});

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		open_d  = open_q;
		cur_d   = cur_q;
		idx_d   = idx_q;
		c_d     = c_q;
		val_d   = val_q;
		b0_d    = b0_q;
		b1_d    = b1_q;
		last_d  = last_q;
		st_d    = st_q;
		clv_d   = clv_q;
		rdb_d   = rdb_q;
		rng_d   = rng_q;

		in_stall      = 1'b1;
		ram_req.we    = 1'b0;
		ram_req.addr  = ent.off_lo;
		ram_req.wdata = ent.wr_lo;

		res.valid            = 1'b0;
		res.word.read_byte   = rdb_q;
		res.word.cluster     = clv_q ? c_q : 12'd0;
		res.word.sector      = clv_q ? (SEC_OFS + {1'b0, c_q}) : 13'd0;
		res.word.status      = st_q;

		case (state_q)
			fcca_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				ram_req.addr  = in_data.byte_index;
				ram_req.wdata = in_data.byte_value;
				ram_req.we    = in_valid && in_rng &&
				                (in_data.mode == fcca_pkg::MODE_WR_BYTE);
				if (in_valid) begin
					st_d   = 1'b0;
					clv_d  = 1'b0;
					rdb_d  = 8'd0;
					rng_d  = in_rng;
					last_d = in_data.last_block;
					case (in_data.mode)
						fcca_pkg::MODE_RD_BYTE: begin
							state_d = fcca_pkg::ST_RD;
						end
						fcca_pkg::MODE_FILE_BLK: begin
							state_d = fcca_pkg::ST_SCAN_A;
							if (!open_q) begin
								phase_d = fcca_pkg::PH_FIRST;
								idx_d   = fcca_pkg::SCAN_START;
							end else begin
								c_d   = cur_q;
								clv_d = 1'b1;
								if (in_data.last_block) begin
									val_d   = fcca_pkg::END_MARK;
									open_d  = 1'b0;
									phase_d = fcca_pkg::PH_FETCH;
									idx_d   = {1'b0, cur_q};
								end else begin
									phase_d = fcca_pkg::PH_LINK;
									idx_d   = fcca_pkg::SCAN_START;
								end
							end
						end
						default: begin
							state_d = fcca_pkg::ST_DONE;
						end
					endcase
				end
			end

			fcca_pkg::ST_RD: begin
				rdb_d   = rng_q ? rdata : 8'd0;
				state_d = fcca_pkg::ST_DONE;
			end

			fcca_pkg::ST_SCAN_A: begin
				if (phase_q == fcca_pkg::PH_FETCH) begin
					// entry outside the table: drop the update
					state_d = ent.fits ? fcca_pkg::ST_SCAN_B : fcca_pkg::ST_DONE;
				end else if (over_lim || !ent.fits) begin
					// scan exhausted, no free entry
					if (phase_q == fcca_pkg::PH_FIRST) begin
						st_d    = 1'b1;
						state_d = fcca_pkg::ST_DONE;
					end else begin
						st_d    = 1'b1;
						val_d   = fcca_pkg::END_MARK;
						open_d  = 1'b0;
						phase_d = fcca_pkg::PH_FETCH;
						idx_d   = {1'b0, c_q};
					end
				end else if (phase_q == fcca_pkg::PH_LINK && idx_q[11:0] == c_q) begin
					idx_d = idx_q + 13'd1;
				end else begin
					state_d = fcca_pkg::ST_SCAN_B;
				end
			end

			fcca_pkg::ST_SCAN_B: begin
				ram_req.addr = ent.off_hi;
				b0_d         = rdata;
				state_d      = fcca_pkg::ST_SCAN_C;
			end

			fcca_pkg::ST_SCAN_C: begin
				state_d = fcca_pkg::ST_SCAN_A;
				if (phase_q == fcca_pkg::PH_FETCH) begin
					b1_d    = rdata;
					state_d = fcca_pkg::ST_WR_LO;
				end else if (ent.value != fcca_pkg::FREE_ENTRY) begin
					idx_d = idx_q + 13'd1;
				end else if (phase_q == fcca_pkg::PH_FIRST) begin
					c_d   = idx_q[11:0];
					clv_d = 1'b1;
					if (last_q) begin
						val_d   = fcca_pkg::END_MARK;
						open_d  = 1'b0;
						phase_d = fcca_pkg::PH_FETCH;
					end else begin
						phase_d = fcca_pkg::PH_LINK;
						idx_d   = fcca_pkg::SCAN_START;
					end
				end else begin
					// link found: chain continues at this entry
					val_d   = idx_q[11:0];
					cur_d   = idx_q[11:0];
					open_d  = 1'b1;
					phase_d = fcca_pkg::PH_FETCH;
					idx_d   = {1'b0, c_q};
				end
			end

			fcca_pkg::ST_WR_LO: begin
				ram_req.we    = 1'b1;
				ram_req.addr  = ent.off_lo;
				ram_req.wdata = ent.wr_lo;
				state_d       = fcca_pkg::ST_WR_HI;
			end

			fcca_pkg::ST_WR_HI: begin
				ram_req.we    = 1'b1;
				ram_req.addr  = ent.off_hi;
				ram_req.wdata = ent.wr_hi;
				state_d       = fcca_pkg::ST_DONE;
			end

			fcca_pkg::ST_DONE: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = fcca_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = fcca_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcca_pkg::ST_IDLE;
			phase_q <= fcca_pkg::PH_FIRST;
			open_q  <= 1'b0;
			cur_q   <= 12'd0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			open_q  <= open_d;
			cur_q   <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		c_q    <= c_d;
		val_q  <= val_d;
		b0_q   <= b0_d;
		b1_q   <= b1_d;
		last_q <= last_d;
		st_q   <= st_d;
		clv_q  <= clv_d;
		rdb_q  <= rdb_d;
		rng_q  <= rng_d;
	end

`ifndef NO_ASSERTIONS
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> (state_q == fcca_pkg::ST_IDLE || state_q == fcca_pkg::ST_WR_LO ||
		                state_q == fcca_pkg::ST_WR_HI))
		else $error("table write outside byte access or entry update");

	a_we_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> ({1'b0, ram_req.addr} < TBL_LIM))
		else $error("table write beyond table");

	a_open_cur: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (cur_q >= 12'd2))
		else $error("open chain holds a reserved cluster number");

	a_fetch_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcca_pkg::ST_SCAN_B && phase_q == fcca_pkg::PH_FETCH)
		|-> (idx_q == {1'b0, c_q}))
		else $error("entry update fetch not at assigned cluster");

	a_wr_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fcca_pkg::ST_WR_LO) |=> (state_q == fcca_pkg::ST_WR_HI))
		else $error("entry update split");
`endif

endmodule

`default_nettype wire

[rtl/core/fat12_cluster_chain_allocator_top.sv]
// FAT12 cluster chain allocator top: APB register, sequencer, table RAM, result register.
// Byte write / no-op: result right after accept; byte read: table byte read, then result.
// File block: a free scan fetches both bytes of each entry it examines, skipping the block's
// own cluster; a found entry in the table is fetched, rewritten low then high, then result.
// One word in flight; the next is taken while a result waits in the output register.
// Reset clears sequencer, chain state, highest_cluster (2848); table not cleared. Uses fcca_*.
`timescale 1ns / 1ps
`default_nettype none

module fat12_cluster_chain_allocator_top #(
	parameter int unsigned TABLE_BYTES   = 8192,
	parameter int unsigned SECTOR_OFFSET = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire fcca_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output fcca_pkg::out_word_t      out_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [1:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	logic [11:0]          highest_q;
	logic [7:0]           rdata;
	fcca_pkg::ram_req_t   ram_req;
	fcca_pkg::result_t    res;
	logic                 res_take;
	logic                 out_valid_q;
	fcca_pkg::out_word_t  out_q;
	logic                 unused_addr;

	// single register: every word address decodes to it
	assign unused_addr = ^paddr;
	assign pready      = 1'b1;
	assign prdata      = {20'd0, highest_q} | {31'd0, unused_addr & 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= 12'd2848;
		end else if (psel && penable && pwrite && pready) begin
			highest_q <= pwdata[11:0];
		end
	end

	fcca_table_ram #(
		.DEPTH (TABLE_BYTES)
	) u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	fcca_ctrl #(
		.TABLE_BYTES   (TABLE_BYTES),
		.SECTOR_OFFSET (SECTOR_OFFSET)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.in_stall (in_stall),
		.highest  (highest_q),
		.rdata    (rdata),
		.ram_req  (ram_req),
		.res      (res),
		.res_take (res_take)
	);

	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			out_q <= res.word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[dv/fat12_cluster_chain_allocator_tb.sv]
// Self-checking testbench for fat12_cluster_chain_allocator_top: byte load and readback,
// cluster chain allocation, disk full and scan-limit settings under random idling.
// Depends on fcca_pkg and the allocator RTL; needs nothing else.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned FAT_BYTES   = 8192;
	localparam int unsigned SEC_BASE    = 31;
	localparam int unsigned NO_CLUSTER  = 4096;
	// Bytes 0..191 hold entries 0..127; no scan in this run goes past entry 126.
	localparam int unsigned SCAN_BYTES  = 192;
	localparam logic [1:0]  HC_REG      = 2'd0;
	localparam logic [11:0] HC_RESET    = 12'd2848;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned LIMIT       = 3000000;
	localparam int unsigned N_PHASES    = 11;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	fcca_pkg::in_word_t  in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	fcca_pkg::out_word_t out_data;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [1:0]          paddr     = '0;
	logic [31:0]         pwdata    = '0;
	logic [31:0]         prdata;
	logic                pready;

	fat12_cluster_chain_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predicted block state.
	logic [7:0]  fat_img [0:FAT_BYTES-1];
	bit          byte_loaded [0:FAT_BYTES-1];
	logic [11:0] chain_next;
	logic        chain_live;
	logic [11:0] scan_top;

	fcca_pkg::in_word_t  host_words[$];
	fcca_pkg::out_word_t due_words[$];

	int unsigned err_count   = 0;
	int unsigned n_items     = 0;
	int unsigned n_blocks    = 0;
	int unsigned n_full      = 0;
	int unsigned n_settings  = 0;
	int unsigned cycle_count = 0;
	bit          idle_en     = 1'b1;
	bit          hold_req    = 1'b0;
	bit          hold_done   = 1'b0;
	int unsigned hold_cnt    = 0;
	int unsigned gap_left    = 0;
	int unsigned stall_left  = 0;
	logic        stall_next;
	fcca_pkg::out_word_t want;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned wanted);
		$display("MISMATCH %s: got 0x%0h, wanted 0x%0h at cycle %0d",
			what, got, wanted, cycle_count);
		err_count++;
	endtask

	function automatic bit entry_fits(int unsigned idx);
		return ((3 * idx) >> 1) + 1 < FAT_BYTES;
	endfunction

	function automatic logic [11:0] entry_value(int unsigned idx);
		int unsigned off = (3 * idx) >> 1;
		if (!entry_fits(idx))
			return fcca_pkg::END_MARK;
		if ((idx & 1) == 0)
			return {fat_img[off+1][3:0], fat_img[off]};
		return {fat_img[off+1], fat_img[off][7:4]};
	endfunction

	// Keep the neighbor's shared nibble.
	function automatic void put_entry(int unsigned idx, logic [11:0] val);
		int unsigned off = (3 * idx) >> 1;
		if (!entry_fits(idx))
			return;
		if ((idx & 1) == 0) begin
			fat_img[off]   = val[7:0];
			fat_img[off+1] = {fat_img[off+1][7:4], val[11:8]};
		end else begin
			fat_img[off]   = {val[3:0], fat_img[off][3:0]};
			fat_img[off+1] = val[11:4];
		end
	endfunction

	function automatic int unsigned lowest_free(int unsigned skip);
		for (int unsigned i = 2; i <= scan_top; i++)
			if (i != skip && entry_fits(i) && entry_value(i) == fcca_pkg::FREE_ENTRY)
				return i;
		return NO_CLUSTER;
	endfunction

	function automatic fcca_pkg::out_word_t allocate_step(fcca_pkg::in_word_t w);
		fcca_pkg::out_word_t r;
		int unsigned c;
		int unsigned n;
		r = '0;
		case (fcca_pkg::mode_t'(w.mode))
			fcca_pkg::MODE_WR_BYTE: begin
				if (w.byte_index < FAT_BYTES)
					fat_img[w.byte_index] = w.byte_value;
			end
			fcca_pkg::MODE_RD_BYTE: begin
				if (w.byte_index < FAT_BYTES)
					r.read_byte = fat_img[w.byte_index];
			end
			fcca_pkg::MODE_FILE_BLK: begin
				c = chain_live ? chain_next : lowest_free(NO_CLUSTER);
				if (c == NO_CLUSTER) begin
					r.status = 1'b1;
				end else begin
					r.cluster = c[11:0];
					r.sector  = 13'(SEC_BASE + c);
					if (w.last_block) begin
						put_entry(c, fcca_pkg::END_MARK);
						chain_live = 1'b0;
					end else begin
						n = lowest_free(c);
						if (n == NO_CLUSTER) begin
							put_entry(c, fcca_pkg::END_MARK);
							chain_live = 1'b0;
							r.status   = 1'b1;
						end else begin
							put_entry(c, n[11:0]);
							chain_next = n[11:0];
							chain_live = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic post_word(input fcca_pkg::mode_t m, input int unsigned idx,
			input int unsigned val, input bit last);
		fcca_pkg::in_word_t w;
		w.mode       = m;
		w.byte_index = idx[12:0];
		w.byte_value = val[7:0];
		w.last_block = last;
		if (m == fcca_pkg::MODE_WR_BYTE)
			byte_loaded[idx] = 1'b1;
		host_words.push_back(w);
	endtask

	// Return once every queued word has been taken and answered, then let the block settle.
	task automatic drain;
		while (host_words.size() != 0 || in_valid || due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_read_check(input logic [11:0] wanted);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= HC_REG;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {20'd0, wanted})
			flag_mismatch("highest_cluster readback", prdata, wanted);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_scan_top(input logic [11:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= HC_REG;
		pwdata  <= {20'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		scan_top  = v;
		n_settings++;
		reg_read_check(v);
	endtask

	// Mostly well-formed file chains, with reads, no-ops and writes refreshing scan bytes.
	task automatic queue_mix(input int unsigned count, input int unsigned top);
		int unsigned made = 0;
		int unsigned pick;
		int unsigned len;
		int unsigned region;
		int unsigned idx;
		int unsigned off;
		bit          cut;
		region = (3 * top) / 2 + 1;
		if (region >= SCAN_BYTES)
			region = SCAN_BYTES - 1;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = $urandom_range(1, 6);
				cut = ($urandom_range(0, 9) == 0);
				for (int unsigned k = 0; k < len; k++)
					post_word(fcca_pkg::MODE_FILE_BLK, $urandom_range(0, FAT_BYTES - 1),
						$urandom_range(0, 255), (k == len - 1) && !cut);
				made += len;
			end else if (pick < 65) begin
				// Free an entry inside the scan range.
				off = (3 * $urandom_range(2, (top < 2) ? 2 : top)) / 2;
				post_word(fcca_pkg::MODE_WR_BYTE, off, 0, $urandom_range(0, 1));
				post_word(fcca_pkg::MODE_WR_BYTE, off + 1, 0, $urandom_range(0, 1));
				made += 2;
			end else if (pick < 80) begin
				idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FAT_BYTES - 1)
					: $urandom_range(0, region);
				post_word(fcca_pkg::MODE_WR_BYTE, idx, $urandom_range(0, 255),
					$urandom_range(0, 1));
				made++;
			end else if (pick < 95) begin
				idx = $urandom_range(0, FAT_BYTES - 1);
				if (!byte_loaded[idx])
					idx = $urandom_range(0, region);
				post_word(fcca_pkg::MODE_RD_BYTE, idx, $urandom_range(0, 255),
					$urandom_range(0, 1));
				made++;
			end else begin
				post_word(fcca_pkg::MODE_NONE, $urandom_range(0, FAT_BYTES - 1),
					$urandom_range(0, 255), $urandom_range(0, 1));
				made++;
			end
		end
	endtask

	// Driver: offer the next word once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				due_words.push_back(allocate_step(in_data));
				n_items++;
			end
			if (in_valid && in_stall) begin
				// hold the stalled word
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (host_words.size() != 0) begin
				in_data  <= host_words.pop_front();
				in_valid <= 1'b1;
				if (idle_en && $urandom_range(0, 5) == 0)
					gap_left = $urandom_range(1, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each taken word against the oldest prediction, drive stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_words.size() == 0) begin
					flag_mismatch("unexpected result word", 32'(out_data), 0);
				end else begin
					want = due_words.pop_front();
					if (out_data.read_byte !== want.read_byte)
						flag_mismatch("read_byte", out_data.read_byte, want.read_byte);
					if (out_data.cluster !== want.cluster)
						flag_mismatch("cluster", out_data.cluster, want.cluster);
					if (out_data.sector !== want.sector)
						flag_mismatch("sector", out_data.sector, want.sector);
					if (out_data.status !== want.status)
						flag_mismatch("status", out_data.status, want.status);
					if (want.cluster != 0 || want.status)
						n_blocks++;
					if (want.status)
						n_full++;
				end
			end
			stall_next = 1'b0;
			if (hold_req && !hold_done) begin
				hold_cnt++;
				if (hold_cnt >= HOLD_CYCLES)
					hold_done = 1'b1;
				else
					stall_next = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				stall_next = 1'b1;
			end
			out_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, due_words.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned top;
		int unsigned count;
		for (int unsigned i = 0; i < FAT_BYTES; i++) begin
			fat_img[i]     = 8'h00;
			byte_loaded[i] = 1'b0;
		end
		chain_next = '0;
		chain_live = 1'b0;
		scan_top   = HC_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		reg_read_check(HC_RESET);

		// Load every byte a scan can reach.
		for (int unsigned i = 0; i < SCAN_BYTES; i++)
			post_word(fcca_pkg::MODE_WR_BYTE, i, 0, i & 1);
		drain();

		// Directed: byte extremes, unused mode, both disk-full cases, scan limit below 2, chains.
		post_word(fcca_pkg::MODE_WR_BYTE, FAT_BYTES - 1, 8'hA5, 1'b0);
		post_word(fcca_pkg::MODE_RD_BYTE, FAT_BYTES - 1, 8'h00, 1'b0);
		post_word(fcca_pkg::MODE_WR_BYTE, 0, 8'hFF, 1'b1);
		post_word(fcca_pkg::MODE_RD_BYTE, 0, 8'hFF, 1'b1);
		post_word(fcca_pkg::MODE_NONE, FAT_BYTES - 1, 8'hFF, 1'b1);
		post_word(fcca_pkg::MODE_RD_BYTE, 6, 8'h5A, 1'b0);
		drain();
		set_scan_top(12'd2);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b0);
		post_word(fcca_pkg::MODE_FILE_BLK, FAT_BYTES - 1, 8'hFF, 1'b1);
		post_word(fcca_pkg::MODE_WR_BYTE, 3, 0, 1'b0);
		post_word(fcca_pkg::MODE_WR_BYTE, 4, 0, 1'b0);
		drain();
		set_scan_top(12'd1);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b1);
		drain();
		set_scan_top(12'd8);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b0);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b0);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b1);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b1);
		for (int unsigned i = 3; i <= 8; i++)
			post_word(fcca_pkg::MODE_RD_BYTE, i, 0, 1'b0);
		drain();
		// Free entries 6 and 7 end both scans well inside the loaded bytes.
		set_scan_top(12'd4094);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b0);
		post_word(fcca_pkg::MODE_FILE_BLK, 0, 0, 1'b1);
		drain();

		// Random phases, each with its own scan limit; the last runs without idling.
		for (int unsigned p = 0; p < N_PHASES; p++) begin
			count = 85;
			if (p == 0)
				top = 2;
			else if (p == 3)
				top = 126;
			else if (p % 2)
				top = $urandom_range(25, 120);
			else
				top = $urandom_range(3, 30);
			if (p == N_PHASES - 1)
				idle_en = 1'b0;
			set_scan_top(top[11:0]);
			queue_mix(count, top);
			if (p == 5)
				hold_req = 1'b1;
			drain();
		end

		repeat (SETTLE) @(posedge clk);
		if (due_words.size() != 0)
			flag_mismatch("results never delivered", 0, due_words.size());
		$display("Ran %0d words over %0d scan-limit settings (reset, 1, 2, 8, 4094, random).",
			n_items, n_settings);
		$display("%0d file blocks answered, %0d of them with disk full.", n_blocks, n_full);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
